### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/rau_pkg.sv
// Package with shared types and constants for the rational arithmetic unit.
package rau_pkg;
    localparam int PART_WIDTH = 32;
    localparam int PROD_W = 2 * PART_WIDTH;
    localparam int CNT_W = $clog2(PROD_W + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RED = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_DONE, S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic comb;
        logic gcd_step;
        logic div_start;
        logic div_load_den;
        logic div_sel_den;
        logic div_step;
        logic div_store;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_err;
        logic gcd_done;
        logic div_done;
    } t_stat;
endpackage

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// One fraction operation at a time: a transfer is taken only when the unit is idle. The
// products are formed in the MUL1, MUL2 and COMB states, a binary gcd of the 64-bit
// numerator and denominator follows, then two shift-subtract divisions by the gcd and a
// range check; an operand error skips straight to the result in the next cycle. The next
// transfer is taken in the cycle after the result transfer.
module rational_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_left_num,
    input  logic signed [31:0] i_left_den,
    input  logic signed [31:0] i_right_num,
    input  logic signed [31:0] i_right_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic [30:0]        o_result_den,
    output logic [1:0]         o_status
);
    rau_pkg::t_cmd  w_cmd;
    rau_pkg::t_stat w_stat;

    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    rau_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_stat(w_stat), .i_opcode(i_opcode),
        .i_left_num(i_left_num), .i_left_den(i_left_den),
        .i_right_num(i_right_num), .i_right_den(i_right_den),
        .o_result_num(o_result_num), .o_result_den(o_result_den), .o_status(o_status)
    );
endmodule

### rtl/rau_datapath.sv
// Datapath: operand split, products, binary gcd and shift-subtract divider.
module rau_datapath (
    input  logic                               i_clk,
    input  rau_pkg::t_cmd                      i_cmd,
    output rau_pkg::t_stat                     o_stat,
    input  logic [2:0]                         i_opcode,
    input  logic signed [31:0]                 i_left_num,
    input  logic signed [31:0]                 i_left_den,
    input  logic signed [31:0]                 i_right_num,
    input  logic signed [31:0]                 i_right_den,
    output logic signed [31:0]                 o_result_num,
    output logic [30:0]                        o_result_den,
    output logic [1:0]                         o_status
);
    localparam int PW = rau_pkg::PART_WIDTH;
    localparam int QW = rau_pkg::PROD_W;
    localparam int CW = rau_pkg::CNT_W;

    // Magnitudes use PW bits because the most negative value has magnitude 2^(PW-1).
    logic [PW-1:0] r_ln, r_ld, r_rn, r_rd;
    logic          r_ls, r_rs;
    logic [2:0]    r_op;
    logic [QW-1:0] r_p1, r_p2, r_p3, r_num, r_den, r_ga, r_gb;
    logic          r_neg;
    logic [CW-1:0] r_shift;
    logic [QW-1:0] r_dq, r_drem, r_dsor, r_qn, r_qd;
    logic [CW-1:0] r_dcnt;
    logic signed [31:0] r_res_num;
    logic [30:0]   r_res_den;
    logic [1:0]    r_status;

    function automatic logic [PW:0] mag(input logic [31:0] raw);
        logic [PW-1:0] v;
        v = raw[PW-1:0];
        return v[PW-1] ? {1'b1, PW'(-v)} : {1'b0, v};
    endfunction

    logic [PW:0] w_ln, w_ld, w_rn, w_rd;
    logic        w_is_red;
    assign w_ln = mag(i_left_num);
    assign w_ld = mag(i_left_den);
    assign w_rn = mag(i_right_num);
    assign w_rd = mag(i_right_den);
    assign w_is_red = (i_opcode > rau_pkg::OP_DIV);

    // Operand checks for the incoming transfer.
    assign o_stat.early_err = (w_ld[PW-1:0] == '0)
        || (!w_is_red && w_rd[PW-1:0] == '0)
        || (i_opcode == rau_pkg::OP_DIV && w_rn[PW-1:0] == '0);

    // Addition terms and combined magnitude.
    logic          w_s2;
    logic [QW-1:0] w_sum, w_dif;
    assign w_s2  = (r_op == rau_pkg::OP_SUB) ? !r_rs : r_rs;
    assign w_sum = r_p1 + r_p2;
    assign w_dif = (r_p1 >= r_p2) ? r_p1 - r_p2 : r_p2 - r_p1;

    // Binary gcd: strip common twos into r_shift, then subtract odd values.
    logic w_ga_ev, w_gb_ev;
    assign w_ga_ev = !r_ga[0];
    assign w_gb_ev = !r_gb[0];
    assign o_stat.gcd_done = (r_gb == '0) || (r_ga == '0);

    assign o_stat.div_done = (r_dcnt == '0);

    logic [QW-1:0] w_g, w_rem_sh;
    logic [QW:0]   w_trial;
    assign w_g = (r_ga | r_gb) << r_shift;
    assign w_rem_sh = {r_drem[QW-2:0], r_dq[QW-1]};
    assign w_trial = {r_drem, r_dq[QW-1]} - {1'b0, r_dsor};

    logic [QW-1:0] w_lim;
    assign w_lim = QW'(1) << (PW - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_ln <= w_ln[PW-1:0];
            r_ld <= w_ld[PW-1:0];
            r_rn <= w_rn[PW-1:0];
            r_rd <= w_rd[PW-1:0];
            r_ls <= (w_ln[PW] != w_ld[PW]) && (w_ln[PW-1:0] != '0);
            r_rs <= (w_rn[PW] != w_rd[PW]) && (w_rn[PW-1:0] != '0);
            r_status <= rau_pkg::ST_ZERO;
            r_res_num <= '0;
            r_res_den <= '0;
        end
        // Two cross products, then the denominator product.
        if (i_cmd.mul1) begin
            r_p1 <= QW'(r_ln) * QW'((r_op == rau_pkg::OP_MUL) ? r_rn : r_rd);
            r_p2 <= QW'(r_rn) * QW'(r_ld);
        end
        if (i_cmd.mul2) begin
            r_p3 <= QW'(r_ld) * QW'((r_op == rau_pkg::OP_DIV) ? r_rn : r_rd);
        end
        // Select numerator, denominator and sign for the opcode.
        if (i_cmd.comb) begin
            unique case (r_op)
                rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                    r_num <= (r_ls == w_s2) ? w_sum : w_dif;
                    r_neg <= (r_ls == w_s2 || r_p1 >= r_p2) ? r_ls : w_s2;
                    r_den <= r_p3;
                end
                rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
                    r_num <= r_p1;
                    r_neg <= r_ls != r_rs;
                    r_den <= r_p3;
                end
                default: begin
                    r_num <= QW'(r_ln);
                    r_neg <= r_ls;
                    r_den <= QW'(r_ld);
                end
            endcase
            r_ga    <= (r_op > rau_pkg::OP_DIV) ? QW'(r_ln)
                     : (r_op >= rau_pkg::OP_MUL) ? r_p1
                     : ((r_ls == w_s2) ? w_sum : w_dif);
            r_gb    <= (r_op > rau_pkg::OP_DIV) ? QW'(r_ld) : r_p3;
            r_shift <= '0;
        end else if (i_cmd.gcd_step) begin
            if (w_ga_ev && w_gb_ev) begin
                r_ga <= r_ga >> 1;
                r_gb <= r_gb >> 1;
                r_shift <= r_shift + CW'(1);
            end else if (w_ga_ev) begin
                r_ga <= r_ga >> 1;
            end else if (w_gb_ev) begin
                r_gb <= r_gb >> 1;
            end else if (r_ga >= r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        // Restoring division of numerator or denominator by the gcd.
        if (i_cmd.div_start) begin
            r_dq   <= i_cmd.div_load_den ? r_den : r_num;
            r_drem <= '0;
            r_dsor <= w_g;
            r_dcnt <= CW'(QW);
        end else if (i_cmd.div_step) begin
            if (!w_trial[QW]) begin
                r_drem <= w_trial[QW-1:0];
                r_dq   <= {r_dq[QW-2:0], 1'b1};
            end else begin
                r_drem <= w_rem_sh;
                r_dq   <= {r_dq[QW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - CW'(1);
        end
        if (i_cmd.div_store) begin
            if (i_cmd.div_sel_den) r_qd <= r_dq;
            else r_qn <= r_dq;
        end
        // Range check and final formatting.
        if (i_cmd.finish) begin
            if (r_qd > w_lim - QW'(1) || r_qn > (r_neg ? w_lim : w_lim - QW'(1))) begin
                r_status  <= rau_pkg::ST_OVF;
                r_res_num <= '0;
                r_res_den <= '0;
            end else begin
                r_status  <= rau_pkg::ST_OK;
                r_res_num <= (r_neg && r_qn != '0) ? -32'(r_qn) : 32'(r_qn);
                r_res_den <= 31'(r_qd);
            end
        end
    end

    assign o_result_num = r_res_num;
    assign o_result_den = r_res_den;
    assign o_status     = r_status;
endmodule

### rtl/rau_ctrl.sv
// Controller state machine sequencing the datapath for one item at a time.
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    rau_pkg::t_state r_state, n_state;
    logic r_sel_den, n_sel_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rau_pkg::S_IDLE;
            r_sel_den <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel_den <= n_sel_den;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_sel_den = r_sel_den;
        o_cmd     = '0;
        o_cmd.div_sel_den = r_sel_den;
        o_stall   = 1'b1;
        o_valid   = 1'b0;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_stat.early_err ? rau_pkg::S_OUT : rau_pkg::S_MUL1;
                end
            end
            rau_pkg::S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = rau_pkg::S_MUL2;
            end
            rau_pkg::S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = rau_pkg::S_COMB;
            end
            rau_pkg::S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state = rau_pkg::S_GCD;
            end
            rau_pkg::S_GCD: begin
                if (i_stat.gcd_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_den = 1'b0;
                    n_sel_den = 1'b0;
                    n_state = rau_pkg::S_DIVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            rau_pkg::S_DIVN: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_load_den = 1'b1;
                    n_sel_den = 1'b1;
                    n_state = rau_pkg::S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            rau_pkg::S_DIVD: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state = rau_pkg::S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            rau_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = rau_pkg::S_OUT;
            end
            rau_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = rau_pkg::S_IDLE;
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end
endmodule

### rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind.
`include "assert_macros.svh"
module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_result_num,
    input logic [30:0]        o_result_den,
    input logic [1:0]         o_status
);
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_status != rau_pkg::ST_OK, o_result_num == 0 && o_result_den == 0)
    `ASSERT_IMPL(a_ok_den, i_clk, i_rst_n, o_valid && o_status == rau_pkg::ST_OK, o_result_den != 0)
    `ASSERT_IMPL(a_one_item, i_clk, i_rst_n, o_valid, o_stall)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_num))
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
